// File: sv/nrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrd_pkg
// Shared types and constants for the Newton-Raphson binary64 divider.
// ----------------------------------------------------------------------------
package nrd_pkg;

   typedef logic [63:0] fp64_type;

   typedef struct packed {
      logic sign;
      logic zero;
   } qflag_type;

   // seed x0 = SEED_OFFSET - SEED_SLOPE * d
   localparam fp64_type SEED_OFFSET = 64'h4006_9696_A000_0000;
   localparam fp64_type SEED_SLOPE  = 64'h3FFE_1E1E_2000_0000;
   localparam fp64_type FP_TWO      = 64'h4000_0000_0000_0000;
   localparam fp64_type FP_INF      = 64'h7FF0_0000_0000_0000;
   localparam logic [10:0] DIV_EXP  = 11'd1022;

   localparam int FMUL_LAT = 4;
   localparam int RSUB_LAT = 2;
   localparam int CELL_LAT = FMUL_LAT + RSUB_LAT + FMUL_LAT;
   localparam int SEED_LAT = FMUL_LAT + RSUB_LAT;

endpackage

`default_nettype wire

// File: sv/nrd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrd_if
// Valid/ready channels for operand beats and quotient beats.
// ----------------------------------------------------------------------------
interface nrd_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] dividend_bits;
   logic [63:0] divisor_bits;

   modport source (output valid, output dividend_bits, output divisor_bits, input ready);
   modport sink   (input valid, input dividend_bits, input divisor_bits, output ready);
endinterface

interface nrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] quotient_bits;

   modport source (output valid, output quotient_bits, input ready);
   modport sink   (input valid, input quotient_bits, output ready);
endinterface

`default_nettype wire

// File: sv/nrd_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrd_delay
// Enabled shift line that keeps side data aligned with the arithmetic stages.
// ----------------------------------------------------------------------------
module nrd_delay #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] d_out
);

   logic [WIDTH-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= d_in;
         for (int i = 1; i < DEPTH; i++) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign d_out = stage_ff[DEPTH-1];

endmodule

`default_nettype wire

// File: sv/nrd_fmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrd_fmul
// Four-stage binary64 multiplier, round to nearest even. Operand b is a
// positive normal below 2; operand a may be zero, subnormal, inf or NaN.
// Results are positive; tiny results are rounded as integer ulp counts.
// ----------------------------------------------------------------------------
module nrd_fmul (
   input  logic              clock,
   input  logic              en,
   input  nrd_pkg::fp64_type a_bits,
   input  nrd_pkg::fp64_type b_bits,
   output nrd_pkg::fp64_type p_bits
);
   import nrd_pkg::*;

   // stage 1: partial products
   logic [10:0] ea, eb, ea_eff;
   logic        a_den, spec;
   logic [52:0] ma, mb;
   fp64_type    spec_bits;

   logic [53:0] pll_ff;
   logic [52:0] plh_ff, phl_ff;
   logic [51:0] phh_ff;
   logic [10:0] ea1_ff, eb1_ff;
   logic        den1_ff, spec1_ff;
   fp64_type    specb1_ff;

   always_comb begin
      ea     = a_bits[62:52];
      eb     = b_bits[62:52];
      a_den  = (ea == 11'd0);
      ma     = {!a_den, a_bits[51:0]};
      mb     = {(eb != 11'd0), b_bits[51:0]};
      ea_eff = a_den ? 11'd1 : ea;
      spec   = (ea == 11'h7FF);
      spec_bits = (a_bits[51:0] == 52'd0) ? FP_INF : {12'h7FF, 1'b1, a_bits[50:0]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pll_ff    <= 54'(ma[26:0]) * 54'(mb[26:0]);
         plh_ff    <= 53'(ma[26:0]) * 53'(mb[52:27]);
         phl_ff    <= 53'(ma[52:27]) * 53'(mb[26:0]);
         phh_ff    <= 52'(ma[52:27]) * 52'(mb[52:27]);
         ea1_ff    <= ea_eff;
         eb1_ff    <= eb;
         den1_ff   <= a_den;
         spec1_ff  <= spec;
         specb1_ff <= spec_bits;
      end
   end

   // stage 2: product sum
   logic [105:0] prod_ff;
   logic [11:0]  esum_ff;
   logic         den2_ff, spec2_ff;
   fp64_type     specb2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= (106'(phh_ff) << 54) + ((106'(plh_ff) + 106'(phl_ff)) << 27)
                      + 106'(pll_ff);
         esum_ff   <= 12'(ea1_ff) + 12'(eb1_ff);
         den2_ff   <= den1_ff;
         spec2_ff  <= spec1_ff;
         specb2_ff <= specb1_ff;
      end
   end

   // stage 3: align to the result ulp, collect round and sticky
   logic [12:0]  ebias;
   logic         tiny;
   logic [12:0]  sraw;
   logic [6:0]   sh_tiny, sh;
   logic [11:0]  fm1;
   logic [107:0] ext, shifted;
   logic         sticky;

   logic [55:0]  mant3_ff;
   logic         rnd3_ff, stk3_ff, spec3_ff;
   logic [11:0]  fm1_3_ff;
   fp64_type     specb3_ff;

   always_comb begin
      ebias = {1'b0, esum_ff} + 13'(prod_ff[105]);
      tiny  = den2_ff || (ebias < 13'd1024);
      sraw  = 13'd1076 - {1'b0, esum_ff};
      if ({1'b0, esum_ff} >= 13'd1076) begin
         sh_tiny = 7'd0;
      end else if (sraw > 13'd127) begin
         sh_tiny = 7'd127;
      end else begin
         sh_tiny = sraw[6:0];
      end
      sh      = tiny ? sh_tiny : (prod_ff[105] ? 7'd53 : 7'd52);
      fm1     = tiny ? 12'd0 : 12'(ebias - 13'd1024);
      ext     = {prod_ff, 2'b00};
      shifted = ext >> sh;
      sticky  = |(ext & ~({108{1'b1}} << ({1'b0, sh} + 8'd1)));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mant3_ff  <= shifted[57:2];
         rnd3_ff   <= shifted[1];
         stk3_ff   <= sticky;
         fm1_3_ff  <= fm1;
         spec3_ff  <= spec2_ff;
         specb3_ff <= specb2_ff;
      end
   end

   // stage 4: round and pack
   logic        inc;
   logic [64:0] total;
   fp64_type    p_ff;

   always_comb begin
      inc   = rnd3_ff & (stk3_ff | mant3_ff[0]);
      total = 65'({fm1_3_ff, 52'd0}) + 65'(mant3_ff) + 65'(inc);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (spec3_ff) begin
            p_ff <= specb3_ff;
         end else if (total >= 65'(FP_INF)) begin
            p_ff <= FP_INF;
         end else begin
            p_ff <= {1'b0, total[62:0]};
         end
      end
   end

   assign p_bits = p_ff;

endmodule

`default_nettype wire

// File: sv/nrd_rsub.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrd_rsub
// Two-stage binary64 subtract k - b, round to nearest even, for k in [2,4)
// and b in [0.5,2); both are exact in a 56-bit fixed format (lsb 2^-54).
// ----------------------------------------------------------------------------
module nrd_rsub (
   input  logic              clock,
   input  logic              en,
   input  nrd_pkg::fp64_type k_bits,
   input  nrd_pkg::fp64_type b_bits,
   output nrd_pkg::fp64_type r_bits
);
   import nrd_pkg::*;

   logic [1:0]  ksh, bsh;
   logic [55:0] kfix, bfix;
   logic [55:0] diff_ff;

   always_comb begin
      ksh  = 2'(k_bits[62:52] - 11'd1021);
      bsh  = 2'(b_bits[62:52] - 11'd1021);
      kfix = 56'({1'b1, k_bits[51:0]}) << ksh;
      bfix = 56'({1'b1, b_bits[51:0]}) << bsh;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= kfix - bfix;
      end
   end

   logic [1:0]  nsh;
   logic [10:0] base;
   logic [55:0] norm;
   logic        inc;
   logic [63:0] total;
   fp64_type    r_ff;

   always_comb begin
      if (diff_ff[55]) begin
         nsh  = 2'd0;
         base = 11'd1023;
      end else if (diff_ff[54]) begin
         nsh  = 2'd1;
         base = 11'd1022;
      end else if (diff_ff[53]) begin
         nsh  = 2'd2;
         base = 11'd1021;
      end else begin
         nsh  = 2'd3;
         base = 11'd1020;
      end
      norm  = diff_ff << nsh;
      inc   = norm[2] & ((|norm[1:0]) | norm[3]);
      total = {1'b0, base, 52'd0} + 64'(norm[55:3]) + 64'(inc);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= total;
      end
   end

   assign r_bits = r_ff;

endmodule

`default_nettype wire

// File: sv/nrd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrd_cell
// One Newton-Raphson step x' = x * (2 - d*x); passes d on to the next cell.
// ----------------------------------------------------------------------------
module nrd_cell (
   input  logic              clock,
   input  logic              en,
   input  nrd_pkg::fp64_type d_in,
   input  nrd_pkg::fp64_type x_in,
   output nrd_pkg::fp64_type d_out,
   output nrd_pkg::fp64_type x_out
);
   import nrd_pkg::*;

   fp64_type dx, corr, x_dly;

   nrd_fmul u_dx (.clock(clock), .en(en), .a_bits(d_in), .b_bits(x_in), .p_bits(dx));

   nrd_rsub u_corr (.clock(clock), .en(en), .k_bits(FP_TWO), .b_bits(dx), .r_bits(corr));

   nrd_delay #(.WIDTH(64), .DEPTH(FMUL_LAT + RSUB_LAT)) u_xdly (
      .clock(clock), .en(en), .d_in(x_in), .d_out(x_dly)
   );

   nrd_fmul u_xn (.clock(clock), .en(en), .a_bits(x_dly), .b_bits(corr), .p_bits(x_out));

   nrd_delay #(.WIDTH(64), .DEPTH(CELL_LAT)) u_ddly (
      .clock(clock), .en(en), .d_in(d_in), .d_out(d_out)
   );

endmodule

`default_nettype wire

// File: sv/newton_raphson_fp64_divider_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// newton_raphson_fp64_divider_unit
// Binary64 divide by reciprocal seed plus a chain of Newton-Raphson cells.
// Throughput: one beat per cycle unless frozen; every cell is fully pipelined.
// Each cell is two 4-stage multipliers around a 2-stage subtractor.
// A two-entry output buffer holds results; the pipe freezes while it is full.
// Reset (synchronous) clears all valid bits and the output buffer.
// ----------------------------------------------------------------------------
module newton_raphson_fp64_divider_unit #(
   parameter int NEWTON_STEPS = 4
) (
   input  logic       clock,
   input  logic       reset,
   nrd_req_if.sink    req_if,
   nrd_rsp_if.source  rsp_if
);
   import nrd_pkg::*;

   localparam int FRONT_LAT = SEED_LAT + NEWTON_STEPS * CELL_LAT;
   localparam int PIPE_LAT  = FRONT_LAT + FMUL_LAT;

   logic en;
   logic fire;

   // operand scaling
   logic        nmag_zero, dmag_zero;
   logic [10:0] enew;
   fp64_type    nscaled, dscaled;
   qflag_type   flags_in, flags_out;

   always_comb begin
      nmag_zero = (req_if.dividend_bits[62:0] == 63'd0);
      dmag_zero = (req_if.divisor_bits[62:0] == 63'd0);
      enew      = nmag_zero ? 11'd0
                : (req_if.dividend_bits[62:52] - req_if.divisor_bits[62:52] + DIV_EXP);
      nscaled   = {1'b0, enew, req_if.dividend_bits[51:0]};
      dscaled   = {1'b0, DIV_EXP, req_if.divisor_bits[51:0]};
      flags_in.sign = req_if.dividend_bits[63] ^ req_if.divisor_bits[63];
      flags_in.zero = nmag_zero | dmag_zero;
   end

   // seed
   fp64_type sd, x0, d0;

   nrd_fmul u_seed_mul (.clock(clock), .en(en), .a_bits(SEED_SLOPE), .b_bits(dscaled),
                        .p_bits(sd));
   nrd_rsub u_seed_sub (.clock(clock), .en(en), .k_bits(SEED_OFFSET), .b_bits(sd),
                        .r_bits(x0));
   nrd_delay #(.WIDTH(64), .DEPTH(SEED_LAT)) u_d0 (
      .clock(clock), .en(en), .d_in(dscaled), .d_out(d0)
   );

   // cell chain
   fp64_type d_chain [NEWTON_STEPS+1];
   fp64_type x_chain [NEWTON_STEPS+1];

   assign d_chain[0] = d0;
   assign x_chain[0] = x0;

   for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_cell
      nrd_cell u_cell (
         .clock (clock),
         .en    (en),
         .d_in  (d_chain[i]),
         .x_in  (x_chain[i]),
         .d_out (d_chain[i+1]),
         .x_out (x_chain[i+1])
      );
   end

   // final product
   fp64_type a_dly, q_mag;

   nrd_delay #(.WIDTH(64), .DEPTH(FRONT_LAT)) u_adly (
      .clock(clock), .en(en), .d_in(nscaled), .d_out(a_dly)
   );
   nrd_delay #(.WIDTH($bits(qflag_type)), .DEPTH(PIPE_LAT)) u_fdly (
      .clock(clock), .en(en), .d_in(flags_in), .d_out(flags_out)
   );
   nrd_fmul u_qmul (.clock(clock), .en(en), .a_bits(a_dly), .b_bits(x_chain[NEWTON_STEPS]),
                    .p_bits(q_mag));

   // valid line
   logic vld_ff [PIPE_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= fire;
         for (int i = 1; i < PIPE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // output register plus skid entry
   fp64_type q_final;
   logic     arrive, take;
   logic     o_valid_ff, o_valid_in, s_valid_ff, s_valid_in;
   fp64_type o_data_ff, o_data_in, s_data_ff, s_data_in;

   always_comb begin
      q_final = {flags_out.sign, flags_out.zero ? 63'd0 : q_mag[62:0]};
      en      = !s_valid_ff;
      fire    = req_if.valid & en;
      arrive  = en & vld_ff[PIPE_LAT-1];
      take    = o_valid_ff & rsp_if.ready;

      o_valid_in = o_valid_ff;
      o_data_in  = o_data_ff;
      s_valid_in = s_valid_ff;
      s_data_in  = s_data_ff;
      if (s_valid_ff) begin
         if (take) begin
            o_data_in  = s_data_ff;
            s_valid_in = 1'b0;
         end
      end else if (arrive) begin
         if (!o_valid_ff || take) begin
            o_valid_in = 1'b1;
            o_data_in  = q_final;
         end else begin
            s_valid_in = 1'b1;
            s_data_in  = q_final;
         end
      end else if (take) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= o_valid_in;
         s_valid_ff <= s_valid_in;
      end
      o_data_ff <= o_data_in;
      s_data_ff <= s_data_in;
   end

   assign req_if.ready         = en;
   assign rsp_if.valid         = o_valid_ff;
   assign rsp_if.quotient_bits = o_data_ff;

   // checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff |-> o_valid_ff)
      else $error("skid entry holds a beat while output register is empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && !rsp_if.ready && arrive) |=> s_valid_ff)
      else $error("arriving beat lost while output stalled");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (s_valid_ff && rsp_if.ready) |=> (!s_valid_ff && o_valid_ff))
      else $error("skid entry not moved to output register");

endmodule

`default_nettype wire
